// ===== rtl/core/voxel_grid_first_point_filter_assert.svh =====
// assertion macros shared by the voxel grid filter rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef VOXEL_GRID_FIRST_POINT_FILTER_ASSERT_SVH
`define VOXEL_GRID_FIRST_POINT_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VGFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define VGFP_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VGFP_ASSERT(label, clk, rst_n, prop)
`define VGFP_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/core/vgfp_pkg.sv =====
// types and constants of the voxel grid first point filter
// no dependencies
package vgfp_pkg;

  localparam int TABLE_DEPTH = 4096;  // power of two
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int MAX_PROBES  = 16;
  localparam int PROBE_W     = $clog2(MAX_PROBES + 1);

  localparam int COORD_W   = 32;
  localparam int EDGE_W    = 31;
  localparam int KEPT_W    = 13;
  localparam int STATUS_W  = 3;
  localparam int DIV_CNT_W = $clog2(COORD_W);

  localparam logic [EDGE_W-1:0]  EDGE_RESET = EDGE_W'(410);
  localparam logic [KEPT_W-1:0]  KEPT_MAX   = {KEPT_W{1'b1}};

  localparam logic [COORD_W-1:0] PRIME_X = 32'd73856093;
  localparam logic [COORD_W-1:0] PRIME_Y = 32'd19349663;
  localparam logic [COORD_W-1:0] PRIME_Z = 32'd83492791;

  typedef enum logic [STATUS_W-1:0] {
    ST_INVALID = 3'd0,
    ST_KEPT    = 3'd1,
    ST_DUP     = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef struct packed {
    logic               used;
    logic [COORD_W-1:0] key_x;
    logic [COORD_W-1:0] key_y;
    logic [COORD_W-1:0] key_z;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/vgfp_if.sv =====
// request and result channel interfaces of the voxel grid filter
// depends on vgfp_pkg
interface vgfp_req_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [vgfp_pkg::COORD_W-1:0] coord_x;
  logic signed [vgfp_pkg::COORD_W-1:0] coord_y;
  logic signed [vgfp_pkg::COORD_W-1:0] coord_z;
  logic                                finite;
  modport source (output valid, command, coord_x, coord_y, coord_z, finite, input ready);
  modport sink (input valid, command, coord_x, coord_y, coord_z, finite, output ready);
endinterface

interface vgfp_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [vgfp_pkg::STATUS_W-1:0]        status;
  logic signed [vgfp_pkg::COORD_W-1:0]  voxel_x;
  logic signed [vgfp_pkg::COORD_W-1:0]  voxel_y;
  logic signed [vgfp_pkg::COORD_W-1:0]  voxel_z;
  logic [vgfp_pkg::KEPT_W-1:0]          kept_total;
  modport source (output valid, status, voxel_x, voxel_y, voxel_z, kept_total, input ready);
  modport sink (input valid, status, voxel_x, voxel_y, voxel_z, kept_total, output ready);
endinterface

// ===== rtl/core/voxel_grid_first_point_filter.sv =====
// voxel grid first point filter: a point request runs through a serial restoring divide,
// a hash of the voxel, bounded linear probes of the slot table and the output register
// one request in flight; an invalid point goes straight to the output, a clear rewrites every slot
// throughput is set by the serial divider and the table read port
// reset: async active low; a pass over all 4096 slots then clears the slot table, no requests taken
// depends on vgfp_pkg, vgfp_if, vgfp_ram and the assertion header
`include "voxel_grid_first_point_filter_assert.svh"
module voxel_grid_first_point_filter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [30:0]     cfg_wdata_i,
  vgfp_req_if.sink        req_i,
  vgfp_rsp_if.source      rsp_o
);

  // one-hot sequencer
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_DIV   = 6'b000100,
    S_HASH  = 6'b001000,
    S_PROBE = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  localparam int CW = vgfp_pkg::COORD_W;
  localparam int AW = vgfp_pkg::ADDR_W;
  localparam int PW = vgfp_pkg::PROBE_W;

  state_e state_q, state_d;

  // voxel edge register
  logic [vgfp_pkg::EDGE_W-1:0] edge_q;
  logic [CW-1:0]               divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= vgfp_pkg::EDGE_RESET;
    end else if (cfg_we_i) begin
      edge_q <= cfg_wdata_i;
    end
  end

  // an edge of zero divides as one
  assign divisor = (edge_q == '0) ? CW'(1) : {1'b0, edge_q};

  // control registers
  logic [AW-1:0]                 clr_q;
  logic                          report_q;
  logic [vgfp_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [1:0]                    hash_cnt_q;
  logic [PW-1:0]                 probe_cnt_q;
  logic                          pend_q;
  logic [PW-1:0]                 pend_idx_q;
  logic [AW-1:0]                 pend_addr_q;
  logic [vgfp_pkg::KEPT_W-1:0]   kept_q;
  vgfp_pkg::status_e             res_status_q;
  logic                          rsp_valid_q;

  // datapath registers
  logic [CW-1:0] rem_q [3];
  logic [CW-1:0] dvd_q [3];
  logic          neg_q [3];
  logic [CW-1:0] vox_q [3];
  logic [CW-1:0] prod_q;
  logic [CW-1:0] hash_q;
  logic [AW-1:0] start_q;

  // memory port
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  vgfp_pkg::entry_t     ram_wdata, ram_rdata;
  logic [vgfp_pkg::ENTRY_W-1:0] ram_rdata_raw;

  vgfp_ram #(
    .WIDTH(vgfp_pkg::ENTRY_W),
    .DEPTH(vgfp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );
  assign ram_rdata = vgfp_pkg::entry_t'(ram_rdata_raw);

  // one restoring divide step per lane
  logic [CW-1:0] coord_in [3];
  logic [CW-1:0] shift_rem [3];
  logic [CW-1:0] step_rem [3];
  logic [CW-1:0] step_dvd [3];
  logic [CW-1:0] fix_vox [3];

  assign coord_in[0] = req_i.coord_x;
  assign coord_in[1] = req_i.coord_y;
  assign coord_in[2] = req_i.coord_z;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      shift_rem[l] = {rem_q[l][CW-2:0], dvd_q[l][CW-1]};
      if (shift_rem[l] >= divisor) begin
        step_rem[l] = shift_rem[l] - divisor;
        step_dvd[l] = {dvd_q[l][CW-2:0], 1'b1};
      end else begin
        step_rem[l] = shift_rem[l];
        step_dvd[l] = {dvd_q[l][CW-2:0], 1'b0};
      end
      // floor for negative numerators: -q, or -q-1 when a remainder is left
      if (!neg_q[l]) begin
        fix_vox[l] = step_dvd[l];
      end else if (step_rem[l] != '0) begin
        fix_vox[l] = ~step_dvd[l];
      end else begin
        fix_vox[l] = -step_dvd[l];
      end
    end
  end

  // hash operand select
  logic [CW-1:0] hash_a, hash_b, hash_full;
  always_comb begin
    case (hash_cnt_q)
      2'd0: begin
        hash_a = vox_q[0];
        hash_b = vgfp_pkg::PRIME_X;
      end
      2'd1: begin
        hash_a = vox_q[1];
        hash_b = vgfp_pkg::PRIME_Y;
      end
      default: begin
        hash_a = vox_q[2];
        hash_b = vgfp_pkg::PRIME_Z;
      end
    endcase
  end
  assign hash_full = hash_q ^ prod_q;

  // probe compare
  logic key_match, last_probe, can_issue;
  assign key_match  = (ram_rdata.key_x == vox_q[0]) && (ram_rdata.key_y == vox_q[1]) &&
                      (ram_rdata.key_z == vox_q[2]);
  assign last_probe = (pend_idx_q == PW'(vgfp_pkg::MAX_PROBES - 1));
  assign can_issue  = (probe_cnt_q < PW'(vgfp_pkg::MAX_PROBES));

  assign req_i.ready = (state_q == S_IDLE);

  // memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_q;
    ram_wdata = '{used: 1'b1, key_x: vox_q[0], key_y: vox_q[1], key_z: vox_q[2]};
    ram_re    = 1'b0;
    ram_raddr = start_q + AW'(probe_cnt_q);
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_PROBE: begin
        ram_re = can_issue;
        ram_we = pend_q && !ram_rdata.used;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.command) begin
            state_d = S_CLEAR;
          end else if (!req_i.finite) begin
            state_d = S_OUT;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_CLEAR: begin
        if (clr_q == AW'(vgfp_pkg::TABLE_DEPTH - 1)) begin
          state_d = report_q ? S_OUT : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_cnt_q == '1) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_cnt_q == 2'd3) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (pend_q && (!ram_rdata.used || key_match || last_probe)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      report_q     <= 1'b0;
      div_cnt_q    <= '0;
      hash_cnt_q   <= '0;
      probe_cnt_q  <= '0;
      pend_q       <= 1'b0;
      kept_q       <= '0;
      res_status_q <= vgfp_pkg::ST_INVALID;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // load a new result once the output register is free, else drain it
      if (state_q == S_OUT && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            clr_q     <= '0;
            report_q  <= 1'b1;
            div_cnt_q <= '0;
            if (req_i.command) begin
              kept_q       <= '0;
              res_status_q <= vgfp_pkg::ST_CLEARED;
            end else begin
              res_status_q <= vgfp_pkg::ST_INVALID;
            end
          end
        end
        S_CLEAR: clr_q <= clr_q + AW'(1);
        S_DIV: begin
          div_cnt_q  <= div_cnt_q + 1'b1;
          hash_cnt_q <= '0;
        end
        S_HASH: begin
          hash_cnt_q  <= hash_cnt_q + 2'd1;
          probe_cnt_q <= '0;
          pend_q      <= 1'b0;
        end
        S_PROBE: begin
          pend_q <= can_issue;
          if (can_issue) begin
            probe_cnt_q <= probe_cnt_q + PW'(1);
          end
          if (pend_q) begin
            if (!ram_rdata.used) begin
              res_status_q <= vgfp_pkg::ST_KEPT;
              if (kept_q != vgfp_pkg::KEPT_MAX) begin
                kept_q <= kept_q + 1'b1;
              end
            end else if (key_match) begin
              res_status_q <= vgfp_pkg::ST_DUP;
            end else begin
              res_status_q <= vgfp_pkg::ST_FULL;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        for (int l = 0; l < 3; l++) begin
          neg_q[l] <= coord_in[l][CW-1];
          dvd_q[l] <= coord_in[l][CW-1] ? -coord_in[l] : coord_in[l];
          rem_q[l] <= '0;
          vox_q[l] <= '0;
        end
      end
      S_DIV: begin
        for (int l = 0; l < 3; l++) begin
          rem_q[l] <= step_rem[l];
          dvd_q[l] <= step_dvd[l];
          if (div_cnt_q == '1) begin
            vox_q[l] <= fix_vox[l];
          end
        end
        hash_q <= '0;
        prod_q <= '0;
      end
      S_HASH: begin
        prod_q  <= hash_a * hash_b;
        hash_q  <= hash_full;
        start_q <= hash_full[AW-1:0];
      end
      S_PROBE: begin
        pend_idx_q  <= probe_cnt_q;
        pend_addr_q <= ram_raddr;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_o.status     <= res_status_q;
      rsp_o.voxel_x    <= vox_q[0];
      rsp_o.voxel_y    <= vox_q[1];
      rsp_o.voxel_z    <= vox_q[2];
      rsp_o.kept_total <= kept_q;
    end
  end
  assign rsp_o.valid = rsp_valid_q;

  // a table write during probing ends the search
  `VGFP_ASSERT(a_write_ends_probe, clk_i, rst_ni, (ram_we && state_q == S_PROBE) |=> (state_q == S_OUT))
  // the kept count only steps up by one or restarts at zero
  `VGFP_ASSERT(a_kept_step, clk_i, rst_ni, $changed(kept_q) |-> (kept_q == '0 || kept_q == $past(kept_q) + 1'b1))
  // a clear result always reports an empty count
  `VGFP_ASSERT(a_clear_zero, clk_i, rst_ni, (rsp_o.valid && rsp_o.status == vgfp_pkg::ST_CLEARED) |-> (rsp_o.kept_total == '0))

endmodule

// ===== rtl/core/vgfp_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module vgfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== test/voxel_grid_first_point_filter_tb.sv =====
// testbench for the voxel grid first point filter: random and directed point requests
// checked against an in-bench predictor; depends on vgfp_pkg, vgfp_if and the rtl
`timescale 1ns / 1ps
module voxel_grid_first_point_filter_tb;

  typedef struct packed {
    logic              command;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic              finite;
  } point_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [12:0]        kept;
  } voxel_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;

  vgfp_req_if req_if ();
  vgfp_rsp_if rsp_if ();

  voxel_grid_first_point_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state: a copy of the slot table, the kept count and the edge
  logic        tbl_used [vgfp_pkg::TABLE_DEPTH];
  logic [31:0] tbl_kx [vgfp_pkg::TABLE_DEPTH];
  logic [31:0] tbl_ky [vgfp_pkg::TABLE_DEPTH];
  logic [31:0] tbl_kz [vgfp_pkg::TABLE_DEPTH];
  logic [12:0] kept_count;
  logic [30:0] edge_len;

  point_req_t pending_points[$];
  voxel_rsp_t expected_voxels[$];
  int mismatch_count = 0;
  int rsp_hold = 0;         // long receiver stall, counted by its own process
  bit rsp_hold_req = 0;
  bit gap_on = 1;
  bit req_acc = 1'b0;       // the offered request was taken at the last rising edge

  // floor division of a signed coordinate by a positive edge
  function automatic logic [31:0] floor_voxel(logic signed [31:0] c, logic [30:0] e);
    longint n, d, q;
    n = c;
    d = (e == 0) ? 1 : e;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q[31:0];
  endfunction

  function automatic voxel_rsp_t classify_point(point_req_t p);
    voxel_rsp_t r;
    logic [31:0] h, vx, vy, vz;
    logic [vgfp_pkg::ADDR_W-1:0] s;
    r = '0;
    if (p.command) begin
      for (int i = 0; i < vgfp_pkg::TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
      kept_count = '0;
      r.status = vgfp_pkg::ST_CLEARED;
    end else if (!p.finite) begin
      r.status = vgfp_pkg::ST_INVALID;
    end else begin
      vx = floor_voxel(p.cx, edge_len);
      vy = floor_voxel(p.cy, edge_len);
      vz = floor_voxel(p.cz, edge_len);
      r.vx = vx;
      r.vy = vy;
      r.vz = vz;
      h = (vx * 32'd73856093) ^ (vy * 32'd19349663) ^ (vz * 32'd83492791);
      r.status = vgfp_pkg::ST_FULL;
      // bounded linear probe from the hashed slot
      for (int i = 0; i < vgfp_pkg::MAX_PROBES; i++) begin
        s = h[vgfp_pkg::ADDR_W-1:0] + vgfp_pkg::ADDR_W'(i);
        if (!tbl_used[s]) begin
          tbl_used[s] = 1'b1;
          tbl_kx[s] = vx;
          tbl_ky[s] = vy;
          tbl_kz[s] = vz;
          if (kept_count != 13'h1FFF) kept_count++;
          r.status = vgfp_pkg::ST_KEPT;
          break;
        end
        if (tbl_kx[s] == vx && tbl_ky[s] == vy && tbl_kz[s] == vz) begin
          r.status = vgfp_pkg::ST_DUP;
          break;
        end
      end
    end
    r.kept = kept_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gap_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // append a request to the driver queue
  task automatic queue_point(point_req_t p);
    pending_points = {pending_points, p};
  endtask

  always @(posedge clk_i) begin
    req_acc <= rst_ni && req_if.valid && req_if.ready;
  end

  // driver: requests change on the falling edge
  int drv_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    point_req_t p;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.command <= 1'b0;
      req_if.coord_x <= '0;
      req_if.coord_y <= '0;
      req_if.coord_z <= '0;
      req_if.finite <= 1'b0;
    end else if (req_if.valid && !req_acc) begin
      // hold the offered request
    end else if (drv_gap > 0) begin
      drv_gap <= drv_gap - 1;
      req_if.valid <= 1'b0;
    end else if (pending_points.size() > 0) begin
      p = pending_points.pop_front();
      req_if.valid <= 1'b1;
      req_if.command <= p.command;
      req_if.coord_x <= p.cx;
      req_if.coord_y <= p.cy;
      req_if.coord_z <= p.cz;
      req_if.finite <= p.finite;
      drv_gap <= pick_gap();
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // receiver ready, with random gaps and an occasional long hold-off
  int rdy_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp_if.ready <= 1'b0;
    end else if (rsp_hold_req) begin
      rsp_hold_req <= 1'b0;
      rsp_hold <= 600;
      rsp_if.ready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap <= rdy_gap - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      rdy_gap <= pick_gap();
    end
  end

  // monitor: accepted requests feed the predictor, accepted results are checked
  always @(posedge clk_i) begin
    point_req_t p;
    voxel_rsp_t w;
    if (rst_ni && req_if.valid && req_if.ready) begin
      p = '{req_if.command, req_if.coord_x, req_if.coord_y, req_if.coord_z, req_if.finite};
      w = classify_point(p);
      expected_voxels = {expected_voxels, w};
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_voxels.size() == 0) begin
        report_mismatch("unexpected result, status", rsp_if.status, -1);
      end else begin
        w = expected_voxels.pop_front();
        if (rsp_if.status !== w.status) report_mismatch("status", rsp_if.status, w.status);
        if (rsp_if.voxel_x !== w.vx) report_mismatch("voxel_x", rsp_if.voxel_x, w.vx);
        if (rsp_if.voxel_y !== w.vy) report_mismatch("voxel_y", rsp_if.voxel_y, w.vy);
        if (rsp_if.voxel_z !== w.vz) report_mismatch("voxel_z", rsp_if.voxel_z, w.vz);
        if (rsp_if.kept_total !== w.kept)
          report_mismatch("kept_total", rsp_if.kept_total, w.kept);
      end
    end
  end

  function automatic point_req_t make_point(logic cmd, logic signed [31:0] x,
                                            logic signed [31:0] y, logic signed [31:0] z,
                                            logic fin);
    point_req_t p;
    p = '{cmd, x, y, z, fin};
    return p;
  endfunction

  // random coordinate: mostly a small cloud so voxels repeat, sometimes anything
  function automatic logic [31:0] rand_coord(int span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic add_cloud(int n, int span);
    point_req_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0)
        p = make_point(1'b1, $urandom, $urandom, $urandom, 1'($urandom));
      else
        p = make_point(1'b0, rand_coord(span), rand_coord(span), rand_coord(span),
                       $urandom_range(0, 15) != 0);
      queue_point(p);
    end
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || req_if.valid || expected_voxels.size() > 0)
      @(posedge clk_i);
    // a short settle before the next phase
    repeat (4200) @(posedge clk_i);
  endtask

  task automatic write_edge(logic [30:0] e);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= e;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    edge_len = e;
  endtask

  initial begin
    for (int i = 0; i < vgfp_pkg::TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
    kept_count = '0;
    edge_len = vgfp_pkg::EDGE_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, both commands, invalid, duplicate
    queue_point(make_point(0, 32'sh7FFFFFFF, 32'sh80000000, 0, 1));
    queue_point(make_point(0, 32'sh7FFFFFFF, 32'sh80000000, 0, 1));
    queue_point(make_point(0, -1, -410, -411, 1));
    queue_point(make_point(0, 409, 410, 411, 1));
    queue_point(make_point(0, 5, 6, 7, 0));
    queue_point(make_point(1, 32'shFFFFFFFF, 32'shFFFFFFFF, -1, 1));
    queue_point(make_point(0, 32'sh7FFFFFFF, 32'sh80000000, 0, 1));
    // same hash base pushes probes along until the probe bound is hit
    for (int i = 0; i < 18; i++)
      queue_point(make_point(0, i * 410 * 4096, 0, 0, 1));
    wait_drained();

    // zero edge is taken as one
    write_edge(31'd0);
    queue_point(make_point(0, -7, 3, 32'sh80000000, 1));
    queue_point(make_point(0, -7, 3, 32'sh80000000, 1));
    wait_drained();

    write_edge(31'h7FFFFFFF);
    add_cloud(40, 32'h7FFFFFFF);
    wait_drained();

    // tiny edge and a wide cloud: mostly distinct voxels spread over the table
    write_edge(31'd1);
    queue_point(make_point(1, 0, 0, 0, 0));
    add_cloud(300, 1 << 20);
    // hold the receiver off while the sender keeps offering
    rsp_hold_req = 1'b1;
    wait_drained();

    write_edge(31'd4096);
    add_cloud(300, 40000);
    wait_drained();

    write_edge(31'($urandom_range(1, 31'h7FFFFFFF)));
    add_cloud(100, 32'h3FFFFFFF);
    wait_drained();

    write_edge(vgfp_pkg::EDGE_RESET);
    gap_on = 0;
    add_cloud(250, 4000);
    wait_drained();
    gap_on = 1;
    add_cloud(300, 2000);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vgfp_pkg.sv
rtl/core/vgfp_if.sv
rtl/core/vgfp_ram.sv
rtl/core/voxel_grid_first_point_filter.sv
test/voxel_grid_first_point_filter_tb.sv
